@@ hw/rtl/rwl_pkg.sv @@
// Shared definitions for the reader-writer lock manager.
// Holds default parameters, field widths, request and status codes, queue control.
// No dependencies.
package rwl_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TID_BITS_DEF    = 6;
    localparam int MAX_READERS_DEF = 255;
    localparam int MAX_RESULTS     = 16;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 3;
    localparam int HOLD_W   = 9;

    localparam logic [FUNC_W-1:0] FN_READ      = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TRY_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_WRITE     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TRY_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_UNLOCK    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRYFAIL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WOKEN    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTHELD  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd6;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

endpackage

@@ hw/rtl/reader_writer_lock_manager_core.sv @@
// Reader-writer lock manager, reader preferring: sequencer, holder count and queues.
// Depends on rwl_pkg and rwl_fifo (one instance per waiting queue).
//
// One lock shared by many threads. Each item on the request channel carries an
// operation and a thread id; each item on the result channel carries a status,
// a thread id, the holder count after that result (-1 while a writer holds the
// lock) and a last mark. Reads are granted while no writer holds the lock, up to
// MAX_READERS; writes only when it is free. Blocked requests wait in per-class
// FIFOs, try requests fail instead. An unlock that frees the lock wakes every waiting
// reader (one result each, oldest first) or else the oldest waiting writer.
// Sequence: a request is accepted into a register, then evaluated once the result
// channel is free; an unlock that wakes a writer pops the writer queue, then emits
// it; one that wakes readers emits them one per cycle from the single holder-count
// adder and the registered read port; each queue's read port yields one waiting
// thread id per cycle while the result channel is not stalled. Unknown operations
// give no result. The request side is stalled while an item is being worked on;
// a finished result waits in the output register.
module reader_writer_lock_manager_core #(
    parameter int QUEUE_DEPTH    = rwl_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = rwl_pkg::TID_BITS_DEF,
    parameter int MAX_READERS    = rwl_pkg::MAX_READERS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [rwl_pkg::FUNC_W-1:0]        i_func,
    input  logic [THREAD_ID_BITS-1:0]         i_thread_id,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [rwl_pkg::STATUS_W-1:0]      o_status,
    output logic [THREAD_ID_BITS-1:0]         o_thread_out,
    output logic signed [rwl_pkg::HOLD_W-1:0] o_holders,
    output logic                              o_last
);
    import rwl_pkg::*;

    // Holder count width: room for MAX_READERS plus a sign for the writer mark.
    localparam int HC_W  = $clog2(MAX_READERS + 1) + 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // Reader queue cap: waking all of them must fit in one answer and the limit.
    localparam int RCAP0 = (QUEUE_DEPTH < MAX_RESULTS) ? QUEUE_DEPTH : MAX_RESULTS;
    localparam int RCAP  = (RCAP0 < MAX_READERS) ? RCAP0 : MAX_READERS;

    localparam logic signed [HC_W-1:0] HC_MAX    = HC_W'(MAX_READERS);
    localparam logic signed [HC_W-1:0] HC_WRITER = '1;
    localparam logic signed [HC_W-1:0] HC_ONE    = HC_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_RWAKE,
        S_WWAKE
    } t_state;

    t_state r_state, n_state;

    logic [FUNC_W-1:0]          r_func;
    logic [THREAD_ID_BITS-1:0]  r_id;
    logic signed [HC_W-1:0]     r_hc, n_hc;

    logic                       r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]        r_status, n_status;
    logic [THREAD_ID_BITS-1:0]  r_thread, n_thread;
    logic signed [HOLD_W-1:0]   r_holders, n_holders;
    logic                       r_last, n_last;

    t_fifo_ctrl                 rq_ctrl, wq_ctrl;
    logic [THREAD_ID_BITS-1:0]  rq_rdata, wq_rdata;
    logic [CNT_W-1:0]           rq_count, wq_count;

    // Shared unit: holder count plus or minus one.
    logic                       alu_dec;
    logic signed [HC_W-1:0]     alu_out;
    logic signed [HC_W-1:0]     unlock_hc;

    logic                       slot_free;
    logic                       in_accept;

    rwl_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (THREAD_ID_BITS)
    ) u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rq_ctrl),
        .i_wdata (r_id),
        .o_rdata (rq_rdata),
        .o_count (rq_count)
    );

    rwl_fifo #(
        .DEPTH  (QUEUE_DEPTH),
        .DATA_W (THREAD_ID_BITS)
    ) u_wq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (wq_ctrl),
        .i_wdata (r_id),
        .o_rdata (wq_rdata),
        .o_count (wq_count)
    );

    // Mask a holder count to the output field, sign extending when narrower.
    function automatic logic signed [HOLD_W-1:0] to_field(input logic signed [HC_W-1:0] h);
        logic [HC_W+HOLD_W-1:0] ext;
        ext = {{HOLD_W{h[HC_W-1]}}, h};
        return ext[HOLD_W-1:0];
    endfunction

    assign slot_free = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;

    // Only an unlock counts down; everything else counts up.
    assign alu_dec   = (r_state == S_EVAL) && (r_func == FN_UNLOCK);
    assign alu_out   = r_hc + (alu_dec ? HC_WRITER : HC_ONE);
    assign unlock_hc = r_hc[HC_W-1] ? '0 : alu_out;

    always_comb begin
        n_state     = r_state;
        n_hc        = r_hc;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_thread    = r_thread;
        n_holders   = r_holders;
        n_last      = r_last;
        rq_ctrl     = '0;
        wq_ctrl     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                if (r_func > FN_UNLOCK) begin
                    // Unknown operation: drop it, no result.
                    n_state = S_IDLE;
                end else if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_thread    = r_id;
                    n_holders   = to_field(r_hc);
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                    case (r_func)
                        FN_READ, FN_TRY_READ: begin
                            if (!r_hc[HC_W-1]) begin
                                if (r_hc >= HC_MAX) begin
                                    n_status = ST_FULL;
                                end else begin
                                    n_hc      = alu_out;
                                    n_status  = ST_GRANTED;
                                    n_holders = to_field(alu_out);
                                end
                            end else if (r_func == FN_TRY_READ) begin
                                n_status = ST_TRYFAIL;
                            end else if (rq_count < CNT_W'(RCAP)) begin
                                rq_ctrl.push = 1'b1;
                                n_status     = ST_QUEUED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        FN_WRITE, FN_TRY_WRITE: begin
                            if (r_hc == '0) begin
                                n_hc      = HC_WRITER;
                                n_status  = ST_GRANTED;
                                n_holders = to_field(HC_WRITER);
                            end else if (r_func == FN_TRY_WRITE) begin
                                n_status = ST_TRYFAIL;
                            end else if (wq_count < CNT_W'(QUEUE_DEPTH)) begin
                                wq_ctrl.push = 1'b1;
                                n_status     = ST_QUEUED;
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        default: begin
                            // unlock
                            if (r_hc == '0) begin
                                n_status  = ST_NOTHELD;
                                n_holders = '0;
                            end else if (unlock_hc == '0 && rq_count != '0) begin
                                // Lock freed with readers waiting: start the wake sweep.
                                n_out_valid  = r_out_valid && i_stall;
                                n_hc         = '0;
                                rq_ctrl.pop  = 1'b1;
                                n_state      = S_RWAKE;
                            end else if (unlock_hc == '0 && wq_count != '0) begin
                                n_out_valid  = r_out_valid && i_stall;
                                n_hc         = '0;
                                wq_ctrl.pop  = 1'b1;
                                n_state      = S_WWAKE;
                            end else begin
                                n_hc      = unlock_hc;
                                n_status  = ST_RELEASED;
                                n_holders = to_field(unlock_hc);
                            end
                        end
                    endcase
                end
            end

            S_RWAKE: begin
                // Emit the reader already fetched from the queue; fetch the next one meanwhile.
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_WOKEN;
                    n_thread    = rq_rdata;
                    n_hc        = alu_out;
                    n_holders   = to_field(alu_out);
                    n_last      = (rq_count == '0);
                    if (rq_count != '0) begin
                        rq_ctrl.pop = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_WWAKE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_WOKEN;
                    n_thread    = wq_rdata;
                    n_hc        = HC_WRITER;
                    n_holders   = to_field(HC_WRITER);
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hc        <= n_hc;
            r_out_valid <= n_out_valid;
        end
        // Payload: hold the request while it is worked on, hold the result until taken.
        if (in_accept) begin
            r_func <= i_func;
            r_id   <= i_thread_id;
        end
        r_status  <= n_status;
        r_thread  <= n_thread;
        r_holders <= n_holders;
        r_last    <= n_last;
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_thread_out = r_thread;
    assign o_holders    = r_holders;
    assign o_last       = r_last;

endmodule

@@ hw/rtl/rwl_fifo.sv @@
// Waiting-thread queue: circular buffer in a memory with a registered read port.
// Depends on rwl_pkg (queue control struct).
module rwl_fifo #(
    parameter int DEPTH  = rwl_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_W = rwl_pkg::TID_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rwl_pkg::t_fifo_ctrl        i_ctrl,
    input  logic [DATA_W-1:0]          i_wdata,
    output logic [DATA_W-1:0]          o_rdata,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import rwl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        if (p == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail] <= i_wdata;
        end
        if (i_ctrl.pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_ctrl.push) begin
                r_tail  <= wrap_inc(r_tail);
                r_count <= r_count + 1'b1;
            end else if (i_ctrl.pop) begin
                r_head  <= wrap_inc(r_head);
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rdata = r_rdata;
    assign o_count = r_count;

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for reader_writer_lock_manager_core: directed script, queue-fill
// and biased random traffic, scored against a behavioral lock model or pinned script values.
// Depends on rwl_pkg and the RTL of reader_writer_lock_manager_core.
module tb_top;
    import rwl_pkg::*;

    // Operation codes the block ignores; used to prove no result comes out.
    localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [HOLD_W-1:0] WRITER_HOLDS = -9'sd1;

    // The reader queue may never hold more than one full wake-up burst.
    localparam int READER_CAP  = (QUEUE_DEPTH_DEF < MAX_RESULTS) ? QUEUE_DEPTH_DEF : MAX_RESULTS;
    localparam int WRITER_CAP  = QUEUE_DEPTH_DEF;
    localparam int RANDOM_REQS = 120;
    localparam int HOLD_CYCLES = 300;
    // Leave margin after the last wake-up for stray results.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 500000;

    typedef enum logic [1:0] {
        MIX_NOISE,
        MIX_READERS,
        MIX_WRITERS,
        MIX_UNLOCKS
    } t_traffic_mix;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [TID_BITS_DEF-1:0]  tid;
        logic signed [HOLD_W-1:0] holders;
        logic                     last;
    } t_lock_result;

    // One line of the directed script; status and holders matter only when pinned.
    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic [TID_BITS_DEF-1:0]  tid;
        bit                       pinned;
        logic [STATUS_W-1:0]      status;
        logic signed [HOLD_W-1:0] holders;
    } t_script_line;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      req_valid   = 1'b0;
    logic                      req_stall;
    logic [FUNC_W-1:0]         req_func    = FN_READ;
    logic [TID_BITS_DEF-1:0]   req_tid     = '0;
    logic                      rsp_valid;
    logic                      rsp_stall   = 1'b0;
    logic [STATUS_W-1:0]       rsp_status;
    logic [TID_BITS_DEF-1:0]   rsp_tid;
    logic signed [HOLD_W-1:0]  rsp_holders;
    logic                      rsp_last;

    // Lock model state: holder count and the two waiting lines.
    int                        lock_holders;
    logic [TID_BITS_DEF-1:0]   waiting_readers[$];
    logic [TID_BITS_DEF-1:0]   waiting_writers[$];

    t_lock_result              step_results[$];
    t_lock_result              pending_results[$];

    int                        n_errors    = 0;
    int                        cycle_cnt   = 0;
    int                        hold_cnt    = 0;
    logic                      hold_req    = 1'b0;
    logic                      hold_done   = 1'b0;
    logic                      steady      = 1'b0;

    t_script_line script [24] = '{
        '{FN_UNLOCK,    6'd0,  1'b1, ST_NOTHELD,  9'sd0},
        '{FN_READ,      6'd0,  1'b1, ST_GRANTED,  9'sd1},
        '{FN_TRY_READ,  6'd63, 1'b1, ST_GRANTED,  9'sd2},
        '{FN_WRITE,     6'd42, 1'b1, ST_QUEUED,   9'sd2},
        '{FN_TRY_WRITE, 6'd21, 1'b1, ST_TRYFAIL,  9'sd2},
        '{FN_UNLOCK,    6'd1,  1'b1, ST_RELEASED, 9'sd1},
        '{FN_UNLOCK,    6'd2,  1'b0, ST_GRANTED,  9'sd0},
        '{FN_READ,      6'd10, 1'b1, ST_QUEUED,   WRITER_HOLDS},
        '{FN_TRY_READ,  6'd11, 1'b1, ST_TRYFAIL,  WRITER_HOLDS},
        '{FN_READ,      6'd12, 1'b1, ST_QUEUED,   WRITER_HOLDS},
        '{FN_WRITE,     6'd13, 1'b1, ST_QUEUED,   WRITER_HOLDS},
        '{FN_SPARE_5,   6'd63, 1'b0, ST_GRANTED,  9'sd0},
        '{FN_SPARE_6,   6'd0,  1'b0, ST_GRANTED,  9'sd0},
        '{FN_SPARE_7,   6'd21, 1'b0, ST_GRANTED,  9'sd0},
        '{FN_UNLOCK,    6'd42, 1'b0, ST_GRANTED,  9'sd0},
        '{FN_TRY_WRITE, 6'd14, 1'b1, ST_TRYFAIL,  9'sd2},
        '{FN_UNLOCK,    6'd10, 1'b1, ST_RELEASED, 9'sd1},
        '{FN_UNLOCK,    6'd12, 1'b0, ST_GRANTED,  9'sd0},
        '{FN_TRY_WRITE, 6'd20, 1'b1, ST_TRYFAIL,  WRITER_HOLDS},
        '{FN_UNLOCK,    6'd13, 1'b1, ST_RELEASED, 9'sd0},
        '{FN_TRY_WRITE, 6'd55, 1'b1, ST_GRANTED,  WRITER_HOLDS},
        '{FN_UNLOCK,    6'd55, 1'b1, ST_RELEASED, 9'sd0},
        '{FN_WRITE,     6'd63, 1'b1, ST_GRANTED,  WRITER_HOLDS},
        '{FN_UNLOCK,    6'd63, 1'b1, ST_RELEASED, 9'sd0}
    };

    reader_writer_lock_manager_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_func       (req_func),
        .i_thread_id  (req_tid),
        .o_valid      (rsp_valid),
        .i_stall      (rsp_stall),
        .o_status     (rsp_status),
        .o_thread_out (rsp_tid),
        .o_holders    (rsp_holders),
        .o_last       (rsp_last)
    );

    always #2 clk = ~clk;

    // Append one predicted result for the request being modeled.
    function automatic void note_result(input logic [STATUS_W-1:0] st,
                                        input logic [TID_BITS_DEF-1:0] tid,
                                        input int holders, input logic last);
        t_lock_result r;
        r.status  = st;
        r.tid     = tid;
        r.holders = holders[HOLD_W-1:0];
        r.last    = last;
        step_results.push_back(r);
    endfunction

    // Advance the lock model by one request and collect what it answers.
    function automatic void model_request(input logic [FUNC_W-1:0] f,
                                          input logic [TID_BITS_DEF-1:0] tid);
        int woken;
        logic [TID_BITS_DEF-1:0] wake_id;
        step_results.delete();
        woken = 0;
        case (f)
            FN_READ, FN_TRY_READ: begin
                if (lock_holders >= 0) begin
                    // Readers get in past waiting writers, up to the reader limit.
                    if (lock_holders >= MAX_READERS_DEF) begin
                        note_result(ST_FULL, tid, lock_holders, 1'b1);
                    end else begin
                        lock_holders++;
                        note_result(ST_GRANTED, tid, lock_holders, 1'b1);
                    end
                end else if (f == FN_TRY_READ) begin
                    note_result(ST_TRYFAIL, tid, lock_holders, 1'b1);
                end else if (waiting_readers.size() < READER_CAP) begin
                    waiting_readers.push_back(tid);
                    note_result(ST_QUEUED, tid, lock_holders, 1'b1);
                end else begin
                    note_result(ST_FULL, tid, lock_holders, 1'b1);
                end
            end
            FN_WRITE, FN_TRY_WRITE: begin
                if (lock_holders == 0) begin
                    lock_holders = -1;
                    note_result(ST_GRANTED, tid, lock_holders, 1'b1);
                end else if (f == FN_TRY_WRITE) begin
                    note_result(ST_TRYFAIL, tid, lock_holders, 1'b1);
                end else if (waiting_writers.size() < WRITER_CAP) begin
                    waiting_writers.push_back(tid);
                    note_result(ST_QUEUED, tid, lock_holders, 1'b1);
                end else begin
                    note_result(ST_FULL, tid, lock_holders, 1'b1);
                end
            end
            FN_UNLOCK: begin
                if (lock_holders == 0) begin
                    note_result(ST_NOTHELD, tid, 0, 1'b1);
                end else begin
                    if (lock_holders < 0) lock_holders = 0;
                    else lock_holders--;
                    if (lock_holders == 0 && waiting_readers.size() > 0) begin
                        // Wake every waiting reader, oldest first, counting holders up.
                        while (waiting_readers.size() > 0 && woken < MAX_RESULTS) begin
                            wake_id = waiting_readers.pop_front();
                            lock_holders++;
                            note_result(ST_WOKEN, wake_id, lock_holders,
                                        waiting_readers.size() == 0);
                            woken++;
                        end
                        step_results[step_results.size()-1].last = 1'b1;
                    end else if (lock_holders == 0 && waiting_writers.size() > 0) begin
                        wake_id = waiting_writers.pop_front();
                        lock_holders = -1;
                        note_result(ST_WOKEN, wake_id, lock_holders, 1'b1);
                    end else begin
                        note_result(ST_RELEASED, tid, lock_holders, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, hold it until taken, then record what it should produce.
    // A pinned item carries its expected status and holder count from the script.
    task automatic offer_request(input logic [FUNC_W-1:0] f,
                                 input logic [TID_BITS_DEF-1:0] tid,
                                 input bit pinned,
                                 input logic [STATUS_W-1:0] pin_status,
                                 input logic signed [HOLD_W-1:0] pin_holders);
        bit taken;
        t_lock_result r;
        while (!steady && $urandom_range(0, 99) < 36) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= f;
        req_tid   <= tid;
        // Sample the stall mid-cycle; the item goes in at the next rising edge.
        do begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end while (!taken);
        model_request(f, tid);
        if (pinned) begin
            r.status  = pin_status;
            r.tid     = tid;
            r.holders = pin_holders;
            r.last    = 1'b1;
            pending_results.push_back(r);
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    // Drop valid and hold until every predicted result has been seen.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Unlock until the model shows a free lock with nobody waiting.
    task automatic release_all();
        while (lock_holders != 0 || waiting_readers.size() != 0 ||
               waiting_writers.size() != 0)
            offer_request(FN_UNLOCK, TID_BITS_DEF'($urandom_range(0, 63)), 1'b0,
                          ST_GRANTED, 9'sd0);
    endtask

    function automatic logic [FUNC_W-1:0] pick_func(input t_traffic_mix mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_READERS:
                return (roll < 60) ? FN_READ : (roll < 75) ? FN_TRY_READ :
                       (roll < 85) ? FN_WRITE : FN_UNLOCK;
            MIX_WRITERS:
                return (roll < 50) ? FN_WRITE : (roll < 65) ? FN_TRY_WRITE :
                       (roll < 75) ? FN_READ : FN_UNLOCK;
            MIX_UNLOCKS:
                return (roll < 60) ? FN_UNLOCK : FUNC_W'($urandom_range(0, 3));
            default:
                return FUNC_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Result side: random stalls, one long hold-off, and a stretch with none.
    always @(posedge clk) begin
        if (hold_cnt != 0) begin
            hold_cnt  <= hold_cnt - 1;
            rsp_stall <= 1'b1;
        end else if (hold_req && !hold_done) begin
            hold_cnt  <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_stall <= 1'b1;
        end else begin
            rsp_stall <= !steady && ($urandom_range(0, 99) < 36);
        end
    end

    // Score each result taken at the coming edge against the oldest prediction.
    always @(negedge clk) begin
        t_lock_result want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
                if (n_errors < 10)
                    $display("tb_top: unexpected result status=%0d tid=%0d holders=%0d last=%0b",
                             rsp_status, rsp_tid, rsp_holders, rsp_last);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_status !== want.status || rsp_tid !== want.tid ||
                    rsp_holders !== want.holders || rsp_last !== want.last) begin
                    if (n_errors < 10)
                        $display({"tb_top: mismatch exp status=%0d tid=%0d holders=%0d ",
                                  "last=%0b got status=%0d tid=%0d holders=%0d last=%0b"},
                                 want.status, want.tid, want.holders, want.last,
                                 rsp_status, rsp_tid, rsp_holders, rsp_last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: end the run if it goes far past the slowest correct pace.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        t_traffic_mix mix;
        int counted;
        int mix_left;
        logic [FUNC_W-1:0] f;

        lock_holders = 0;
        counted      = 0;
        mix_left     = 0;
        mix          = MIX_NOISE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script: edges of every operation, with the ignored codes among them.
        foreach (script[i])
            offer_request(script[i].func, script[i].tid, script[i].pinned,
                          script[i].status, script[i].holders);

        // Fill both waiting lines past capacity under a writer, then wake a full
        // burst of readers and unwind everything.
        offer_request(FN_WRITE, TID_BITS_DEF'($urandom_range(0, 63)), 1'b0,
                      ST_GRANTED, 9'sd0);
        repeat (READER_CAP + 1)
            offer_request(FN_READ, TID_BITS_DEF'($urandom_range(0, 63)), 1'b0,
                          ST_GRANTED, 9'sd0);
        repeat (WRITER_CAP + 1)
            offer_request(FN_WRITE, TID_BITS_DEF'($urandom_range(0, 63)), 1'b0,
                          ST_GRANTED, 9'sd0);
        release_all();

        // Random traffic in phases of one mix each; ignored codes do not count.
        while (counted < RANDOM_REQS) begin
            if (mix_left == 0) begin
                mix      = t_traffic_mix'($urandom_range(0, 3));
                mix_left = $urandom_range(10, 30);
            end
            mix_left--;
            if (counted == 20) hold_req <= 1'b1;
            steady <= (counted >= 70 && counted < 110);
            if (counted == 50) wait_drained();
            f = pick_func(mix);
            offer_request(f, TID_BITS_DEF'($urandom_range(0, 63)), 1'b0, ST_GRANTED, 9'sd0);
            if (f <= FN_UNLOCK) counted++;
        end
        steady <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
